/* hdl/sctm_pkg.sv */
// Shared types, constants and helpers for the split cache timing model.
package sctm_pkg;

   function automatic int floor_log2(input int v);
      int b;
      int x;
      b = 0;
      x = v;
      while (x > 1) begin
         x = x >> 1;
         b = b + 1;
      end
      return b;
   endfunction

   localparam int NUM_LINES      = 128;
   localparam int WORDS_PER_LINE = 4;

   localparam int WBITS   = floor_log2(WORDS_PER_LINE);
   localparam int LBITS   = floor_log2(NUM_LINES);
   localparam int WORDS   = 1 << WBITS;
   localparam int LINES   = 1 << LBITS;
   localparam int OFF_W   = (WBITS > 0) ? WBITS : 1;
   localparam int TAG_W   = 32 - 2 - WBITS - LBITS;
   localparam int CNT_W   = $clog2(WORDS + 1);

   localparam int MISS_BASE_CYCLES = 8;
   localparam int FILL_WORD_CYCLES = 2;

   localparam int ADDR_W    = 32;
   localparam int PENALTY_W = 8;

   typedef enum logic [1:0] {
      REQ_FETCH = 2'd0,
      REQ_READ  = 2'd1,
      REQ_WRITE = 2'd2
   } req_code_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_LOOKUP = 1'b1
   } state_type;

   typedef struct packed {
      logic lookup;
      logic accept;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic rsp_busy;
   } dp_status_type;

endpackage

/* hdl/sctm_if.sv */
// Handshake interfaces for the request and response channels.
interface sctm_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    req_type;
   logic [sctm_pkg::ADDR_W-1:0]   address;

   modport source (output valid, output req_type, output address, input ready);
   modport sink   (input valid, input req_type, input address, output ready);
endinterface

interface sctm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           hit;
   logic [sctm_pkg::PENALTY_W-1:0] penalty_cycles;

   modport source (output valid, output hit, output penalty_cycles, input ready);
   modport sink   (input valid, input hit, input penalty_cycles, output ready);
endinterface

/* hdl/sctm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sctm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/sctm_ctrl.sv */
// Controller state machine: accepts a request, then finishes the lookup.
module sctm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  sctm_pkg::dp_status_type status,
   output sctm_pkg::ctrl_cmd_type  cmd
);

   sctm_pkg::state_type state_ff;
   sctm_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sctm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sctm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = sctm_pkg::ST_LOOKUP;
            end
         end
         sctm_pkg::ST_LOOKUP: begin
            if (!status.rsp_busy) begin
               state_in = sctm_pkg::ST_IDLE;
            end
         end
         default: state_in = sctm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         sctm_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         sctm_pkg::ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            cmd.finish = !status.rsp_busy;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

/* hdl/sctm_datapath.sv */
// Datapath: tag and dirty RAMs, valid bits, hit check, penalty and response register.
module sctm_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  sctm_pkg::ctrl_cmd_type             cmd,
   output sctm_pkg::dp_status_type            status,
   input  logic [1:0]                         req_type,
   input  logic [sctm_pkg::ADDR_W-1:0]        address,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic                               rsp_hit,
   output logic [sctm_pkg::PENALTY_W-1:0]     rsp_penalty
);

   localparam int LBITS = sctm_pkg::LBITS;
   localparam int WORDS = sctm_pkg::WORDS;
   localparam int TAG_W = sctm_pkg::TAG_W;
   localparam int OFF_W = sctm_pkg::OFF_W;
   localparam int CNT_W = sctm_pkg::CNT_W;
   localparam int PW    = sctm_pkg::PENALTY_W;

   function automatic logic [CNT_W-1:0] popcount(input logic [WORDS-1:0] v);
      logic [CNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < WORDS; i++) begin
         n = n + CNT_W'(v[i]);
      end
      return n;
   endfunction

   logic [1:0]                  req_type_ff;
   logic [sctm_pkg::ADDR_W-1:0] address_ff;
   logic [sctm_pkg::LINES-1:0]  inst_valid_ff;
   logic [sctm_pkg::LINES-1:0]  data_valid_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic                        rsp_hit_ff;
   logic [PW-1:0]               rsp_penalty_ff;

   logic [OFF_W-1:0] off;
   logic [LBITS-1:0] idx;
   logic [LBITS-1:0] req_idx;
   logic [LBITS-1:0] rd_idx;
   logic [TAG_W-1:0] tag;
   logic [TAG_W-1:0] inst_tag_rd;
   logic [TAG_W-1:0] data_tag_rd;
   logic [WORDS-1:0] dirty_rd;
   logic [WORDS-1:0] dirty_wr;
   logic [WORDS-1:0] word_mask;
   logic             is_fetch;
   logic             is_read;
   logic             inst_hit;
   logic             data_hit;
   logic             hit;
   logic             line_valid;
   logic             wb_due;
   logic [PW-1:0]    refill;
   logic [PW-1:0]    writeback;
   logic [PW-1:0]    penalty;
   logic             inst_tag_we;
   logic             data_tag_we;
   logic             dirty_we;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_type_ff <= req_type;
         address_ff  <= address;
      end
   end

   assign off     = OFF_W'((address_ff >> 2) & 32'(WORDS - 1));
   assign idx     = LBITS'(address_ff >> (2 + sctm_pkg::WBITS));
   assign req_idx = LBITS'(address >> (2 + sctm_pkg::WBITS));
   assign tag     = TAG_W'(address_ff >> (2 + sctm_pkg::WBITS + LBITS));
   // The RAMs see the incoming index while idle so the registered tags are ready in lookup.
   assign rd_idx  = cmd.lookup ? idx : req_idx;

   assign is_fetch = (req_type_ff == sctm_pkg::REQ_FETCH);
   assign is_read  = (req_type_ff == sctm_pkg::REQ_READ);

   assign line_valid = data_valid_ff[idx];
   assign inst_hit   = inst_valid_ff[idx] && (inst_tag_rd == tag);
   assign data_hit   = line_valid && (data_tag_rd == tag);
   assign hit        = is_fetch ? inst_hit : data_hit;

   assign word_mask = WORDS'(1) << off;
   assign wb_due    = !is_fetch && line_valid && ((dirty_rd & word_mask) != '0);

   assign refill = PW'(sctm_pkg::MISS_BASE_CYCLES)
                 + PW'(sctm_pkg::FILL_WORD_CYCLES) * (PW'(off) + PW'(1))
                 + (PW'(WORDS - 1) - PW'(off));
   assign writeback = wb_due ? PW'(popcount(dirty_rd)) : '0;
   assign penalty   = hit ? '0 : (refill + writeback);

   assign inst_tag_we = cmd.finish && is_fetch && !inst_hit;
   assign data_tag_we = cmd.finish && !is_fetch && !data_hit;
   assign dirty_we    = cmd.finish && !is_fetch && (!data_hit || !is_read);
   assign dirty_wr    = (data_hit ? dirty_rd : '0) | (is_read ? '0 : word_mask);

   sctm_ram #(.WIDTH(TAG_W), .DEPTH(sctm_pkg::LINES)) u_inst_tag (
      .clock  (clock),
      .wr_en  (inst_tag_we),
      .wr_addr(idx),
      .wr_data(tag),
      .rd_addr(rd_idx),
      .rd_data(inst_tag_rd)
   );

   sctm_ram #(.WIDTH(TAG_W), .DEPTH(sctm_pkg::LINES)) u_data_tag (
      .clock  (clock),
      .wr_en  (data_tag_we),
      .wr_addr(idx),
      .wr_data(tag),
      .rd_addr(rd_idx),
      .rd_data(data_tag_rd)
   );

   // Dirty bits are only consulted while the line is valid, and a refill rewrites them.
   sctm_ram #(.WIDTH(WORDS), .DEPTH(sctm_pkg::LINES)) u_data_dirty (
      .clock  (clock),
      .wr_en  (dirty_we),
      .wr_addr(idx),
      .wr_data(dirty_wr),
      .rd_addr(rd_idx),
      .rd_data(dirty_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         inst_valid_ff <= '0;
         data_valid_ff <= '0;
      end else begin
         if (inst_tag_we) begin
            inst_valid_ff[idx] <= 1'b1;
         end
         if (data_tag_we) begin
            data_valid_ff[idx] <= 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_hit_ff     <= hit;
         rsp_penalty_ff <= penalty;
      end
   end

   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_penalty     = rsp_penalty_ff;

   a_finish_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished lookup did not present a response");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !(rsp_valid_ff && !rsp_ready))
      else $error("response register overwritten while stalled");

   a_hit_no_penalty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_hit_ff) |-> (rsp_penalty_ff == '0))
      else $error("hit charged a penalty");

   a_miss_min_penalty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_hit_ff) |->
         (rsp_penalty_ff >= PW'(sctm_pkg::MISS_BASE_CYCLES + WORDS + 1)))
      else $error("miss penalty below refill minimum");

   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> !cmd.lookup)
      else $error("request accepted during a lookup");

endmodule

/* hdl/split_cache_timing_model_unit.sv */
// Top level of the split instruction/data cache timing model.
//
//   channel   dir   handshake            payload
//   req_if    in    valid/ready          req_type[1:0], address[31:0]
//   rsp_if    out   valid/ready          hit, penalty_cycles[7:0]
//
// A transaction is accepted in idle, which reads the tag and dirty RAMs, then lookup checks
// the line, updates it and loads the response register.
// A new request is taken while an earlier response still waits in the register.
// The lookup holds only when the response register is full and not being drained.
// Reset is synchronous and clears all valid bits at once; there is no clearing pass.
module split_cache_timing_model_unit (
   input  logic  clock,
   input  logic  reset,
   sctm_req_if.sink   req_if,
   sctm_rsp_if.source rsp_if
);

   sctm_pkg::ctrl_cmd_type  cmd;
   sctm_pkg::dp_status_type status;

   sctm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_if.valid),
      .req_ready(req_if.ready),
      .status   (status),
      .cmd      (cmd)
   );

   sctm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_type   (req_if.req_type),
      .address    (req_if.address),
      .rsp_ready  (rsp_if.ready),
      .rsp_valid  (rsp_if.valid),
      .rsp_hit    (rsp_if.hit),
      .rsp_penalty(rsp_if.penalty_cycles)
   );

endmodule

/* tb/sv/tb_top.sv */
// Testbench for the split cache timing model: directed and random accesses checked against a predictor.
module tb_top;

   localparam int TAG_W            = sctm_pkg::TAG_W;
   localparam int LINES            = sctm_pkg::LINES;
   localparam int WORDS            = sctm_pkg::WORDS;
   localparam int WBITS            = sctm_pkg::WBITS;
   localparam int LBITS            = sctm_pkg::LBITS;
   localparam int ADDR_W           = sctm_pkg::ADDR_W;
   localparam int PENALTY_W        = sctm_pkg::PENALTY_W;
   localparam int MISS_BASE_CYCLES = sctm_pkg::MISS_BASE_CYCLES;
   localparam int FILL_WORD_CYCLES = sctm_pkg::FILL_WORD_CYCLES;

   // Request code 3 is not named in the package; the block treats it as a data write.
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PER_PHASE = 150;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      logic                 hit;
      logic [PENALTY_W-1:0] penalty;
   } access_timing_type;

   class cache_timing_scoreboard;
      bit [TAG_W-1:0] inst_tag_q[LINES];
      bit             inst_valid_q[LINES];
      bit [TAG_W-1:0] data_tag_q[LINES];
      bit             data_valid_q[LINES];
      bit [WORDS-1:0] data_dirty_q[LINES];
      access_timing_type expected_timing_q[$];
      int             mismatches;

      function void note_request(input logic [1:0] rt, input logic [ADDR_W-1:0] a);
         int unsigned    word_addr;
         int unsigned    off;
         int unsigned    idx;
         bit [TAG_W-1:0] tag;
         int unsigned    refill;
         int unsigned    pen;
         access_timing_type res;
         word_addr = a >> 2;
         off = word_addr % WORDS;
         idx = (word_addr >> WBITS) % LINES;
         tag = TAG_W'(a >> (2 + WBITS + LBITS));
         refill = MISS_BASE_CYCLES + FILL_WORD_CYCLES * (off + 1) + (WORDS - 1 - off);
         pen = 0;
         if (rt == sctm_pkg::REQ_FETCH) begin
            res.hit = inst_valid_q[idx] && (inst_tag_q[idx] == tag);
            if (!res.hit) begin
               pen = refill;
               inst_tag_q[idx] = tag;
               inst_valid_q[idx] = 1'b1;
            end
         end else begin
            res.hit = data_valid_q[idx] && (data_tag_q[idx] == tag);
            if (!res.hit) begin
               // The victim is written back only when the requested word is dirty.
               if (data_valid_q[idx] && data_dirty_q[idx][off])
                  pen += $countones(data_dirty_q[idx]);
               pen += refill;
               data_tag_q[idx] = tag;
               data_valid_q[idx] = 1'b1;
               data_dirty_q[idx] = '0;
            end
            if (rt != sctm_pkg::REQ_READ)
               data_dirty_q[idx][off] = 1'b1;
         end
         res.penalty = (pen > 255) ? 8'd255 : pen[PENALTY_W-1:0];
         expected_timing_q.push_back(res);
      endfunction

      function void check_response(input logic h, input logic [PENALTY_W-1:0] p);
         access_timing_type exp_res;
         if (expected_timing_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response: hit=%0d penalty=%0d", h, p);
            return;
         end
         exp_res = expected_timing_q.pop_front();
         if (h !== exp_res.hit || p !== exp_res.penalty) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display({"response mismatch: expected hit=%0d penalty=%0d,",
                         " got hit=%0d penalty=%0d"},
                        exp_res.hit, exp_res.penalty, h, p);
         end
      endfunction

      function int pending();
         return expected_timing_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   idle_send_pct;
   int   stall_pct;
   int   quiet_cycles;
   logic [TAG_W-1:0] tag_pool[4];

   cache_timing_scoreboard sb = new();

   sctm_req_if req_bus();
   sctm_rsp_if rsp_bus();

   split_cache_timing_model_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [ADDR_W-1:0] make_addr(input logic [TAG_W-1:0] t, input int idx,
                                                    input int off);
      return (32'(t) << (2 + WBITS + LBITS)) | (32'(idx % LINES) << (2 + WBITS))
             | (32'(off % WORDS) << 2);
   endfunction

   // Called right after a rising edge; returns at the edge that accepted the transaction.
   task automatic send_request(input logic [1:0] rt, input logic [ADDR_W-1:0] a);
      while ($urandom_range(0, 99) < idle_send_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= rt;
      req_bus.address  <= a;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      sb.note_request(rt, a);
   endtask

   task automatic send_random_request();
      int unsigned      pick;
      logic [1:0]       rt;
      logic [ADDR_W-1:0] a;
      pick = $urandom_range(0, 99);
      if (pick < 30)
         rt = sctm_pkg::REQ_FETCH;
      else if (pick < 60)
         rt = sctm_pkg::REQ_READ;
      else if (pick < 95)
         rt = sctm_pkg::REQ_WRITE;
      else
         rt = REQ_UNUSED;
      // Mostly a few tags over a few lines, so hits, conflicts and write-backs are common.
      if ($urandom_range(0, 9) < 7)
         a = make_addr(tag_pool[$urandom_range(0, 3)], $urandom_range(0, 7),
                       $urandom_range(0, WORDS - 1)) | $urandom_range(0, 3);
      else
         a = $urandom;
      send_request(rt, a);
   endtask

   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      do
         @(posedge clock);
      while (sb.pending() != 0);
   endtask

   // Response side: check accepted transactions and stall at random.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            sb.check_response(rsp_bus.hit, rsp_bus.penalty_cycles);
         rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("TB_ERROR");
               $finish;
            end
         end
      end
   end

   initial begin
      int send_pcts[4];
      int stall_pcts[4];
      send_pcts  = '{0, 78, 0, 36};
      stall_pcts = '{0, 0, 78, 36};
      idle_send_pct = 0;
      stall_pct = 0;
      reset = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.req_type = sctm_pkg::REQ_FETCH;
      req_bus.address  = '0;
      tag_pool[0] = '0;
      tag_pool[1] = '1;
      tag_pool[2] = TAG_W'($urandom);
      tag_pool[3] = TAG_W'($urandom);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: cold misses, hits, both sides of one index, write-back with and without
      // the requested word dirty, the unused request code and the address extremes.
      send_request(sctm_pkg::REQ_FETCH, make_addr('0, 0, 0));
      send_request(sctm_pkg::REQ_FETCH, make_addr('0, 0, 0));
      send_request(sctm_pkg::REQ_FETCH, 32'hFFFF_FFFF);
      send_request(sctm_pkg::REQ_FETCH, 32'hFFFF_FFFC);
      send_request(sctm_pkg::REQ_READ,  make_addr('0, 0, 0));
      send_request(sctm_pkg::REQ_WRITE, make_addr('0, 0, 3));
      send_request(sctm_pkg::REQ_WRITE, make_addr('0, 0, 1));
      send_request(sctm_pkg::REQ_READ,  make_addr(TAG_W'(1), 0, 0));
      send_request(sctm_pkg::REQ_WRITE, make_addr(TAG_W'(1), 0, 2));
      send_request(sctm_pkg::REQ_READ,  make_addr(TAG_W'(2), 0, 2));
      send_request(REQ_UNUSED,          make_addr(TAG_W'(2), 0, 0));
      send_request(sctm_pkg::REQ_WRITE, make_addr(TAG_W'(2), 0, 1));
      send_request(sctm_pkg::REQ_WRITE, make_addr(TAG_W'(2), 0, 2));
      send_request(sctm_pkg::REQ_WRITE, make_addr(TAG_W'(2), 0, 3));
      send_request(sctm_pkg::REQ_WRITE, make_addr(TAG_W'(3), 0, 3));
      send_request(sctm_pkg::REQ_WRITE, make_addr(TAG_W'(5), 5, 2));
      send_request(sctm_pkg::REQ_READ,  32'hFFFF_FFFC);
      send_request(sctm_pkg::REQ_WRITE, 32'hFFFF_FFFF);
      send_request(sctm_pkg::REQ_READ,  32'hFFFF_FFF3);
      send_request(sctm_pkg::REQ_FETCH, make_addr(21'h155555, 42, 1));
      send_request(sctm_pkg::REQ_WRITE, make_addr(21'h0AAAAA, 85, 2));
      send_request(sctm_pkg::REQ_READ,  make_addr(21'h0AAAAA, 85, 2));
      drain_responses();

      for (int ph = 0; ph < 4; ph++) begin
         idle_send_pct = send_pcts[ph];
         stall_pct = stall_pcts[ph];
         for (int n = 0; n < RANDOM_PER_PHASE; n++)
            send_random_request();
         drain_responses();
      end

      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
